// File: rtl/core/assert_macros.svh
// Assertion macros used by the SHA-1 digest core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked outside reset.
`define ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/core/sha1md_pkg.sv
// Package with SHA-1 constants, command/status types and helper functions.
package sha1md_pkg;

    localparam logic [31:0] H0_INIT = 32'h67452301;
    localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
    localparam logic [31:0] H2_INIT = 32'h98BADCFE;
    localparam logic [31:0] H3_INIT = 32'h10325476;
    localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

    localparam logic [31:0] K_R0 = 32'h5A827999;
    localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_R3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [6:0] ROUND_LAST  = 7'd79;
    localparam logic [6:0] ROUND_PH1   = 7'd20;
    localparam logic [6:0] ROUND_PH2   = 7'd40;
    localparam logic [6:0] ROUND_PH3   = 7'd60;
    localparam logic [5:0] POS_LAST    = 6'd63;
    localparam logic [5:0] POS_LEN_MIN = 6'd56;
    localparam logic [2:0] DIGEST_LAST = 3'd4;

    typedef struct packed {
        logic       byte_wr;
        logic       pad;
        logic       len_blk;
        logic       load;
        logic       round;
        logic       fold;
        logic       clear;
        logic [2:0] out_sel;
    } sha1md_cmd_t;

    typedef struct packed {
        logic pos_last;
        logic pos_ge56;
        logic round_last;
    } sha1md_sts_t;

    // Place one byte into a word at byte offset ofs, big-endian.
    function automatic logic [31:0] put_byte(input logic [31:0] old_word,
                                             input logic [7:0]  val,
                                             input logic [1:0]  ofs);
        logic [31:0] res;
        case (ofs)
            2'd0:    res = {val, 24'h000000};
            2'd1:    res = old_word | {8'h00, val, 16'h0000};
            2'd2:    res = old_word | {16'h0000, val, 8'h00};
            default: res = old_word | {24'h000000, val};
        endcase
        return res;
    endfunction

endpackage

// File: rtl/core/sha1md_datapath.sv
// SHA-1 datapath: block store, message schedule, round logic and chaining words.
module sha1md_datapath (
    input  logic                     clk,
    input  logic                     rst_n,
    input  sha1md_pkg::sha1md_cmd_t  cmd,
    input  logic [7:0]               message_byte,
    output sha1md_pkg::sha1md_sts_t  sts,
    output logic [31:0]              digest_word
);
    import sha1md_pkg::*;

    logic [31:0] w_reg     [16];
    logic [31:0] w_next    [16];
    logic [31:0] chain_reg [5];
    logic [31:0] chain_next[5];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0] a_next, b_next, c_next, d_next, e_next;
    logic [5:0]  pos_reg, pos_next;
    logic [60:0] len_reg, len_next;
    logic [6:0]  rnd_reg, rnd_next;

    logic [63:0] len_bits;
    logic [31:0] f_val, k_val, t_val, sched_val;

    assign len_bits  = {len_reg, 3'b000};
    assign sched_val = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];

    always_comb
    begin
        if (rnd_reg < ROUND_PH1)
        begin
            f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            k_val = K_R0;
        end
        else if (rnd_reg < ROUND_PH2)
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K_R1;
        end
        else if (rnd_reg < ROUND_PH3)
        begin
            f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_val = K_R2;
        end
        else
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K_R3;
        end
    end

    assign t_val = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + k_val + w_reg[0];

    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            w_next[i] = w_reg[i];
        end
        for (int i = 0; i < 5; i++)
        begin
            chain_next[i] = chain_reg[i];
        end
        a_next   = a_reg;
        b_next   = b_reg;
        c_next   = c_reg;
        d_next   = d_reg;
        e_next   = e_reg;
        pos_next = pos_reg;
        len_next = len_reg;
        rnd_next = rnd_reg;

        if (cmd.byte_wr)
        begin
            w_next[pos_reg[5:2]] = put_byte(w_reg[pos_reg[5:2]], message_byte, pos_reg[1:0]);
            pos_next = pos_reg + 6'd1;
            len_next = len_reg + 61'd1;
        end

        if (cmd.pad)
        begin
            // Pad byte at the current offset, zero every later word, length if it fits.
            for (int i = 0; i < 16; i++)
            begin
                if (4'(i) > pos_reg[5:2])
                begin
                    w_next[i] = 32'h0;
                end
            end
            w_next[pos_reg[5:2]] = put_byte(w_reg[pos_reg[5:2]], PAD_BYTE, pos_reg[1:0]);
            if (!sts.pos_ge56)
            begin
                w_next[14] = len_bits[63:32];
                w_next[15] = len_bits[31:0];
            end
        end

        if (cmd.len_blk)
        begin
            for (int i = 0; i < 14; i++)
            begin
                w_next[i] = 32'h0;
            end
            w_next[14] = len_bits[63:32];
            w_next[15] = len_bits[31:0];
        end

        if (cmd.load)
        begin
            a_next   = chain_reg[0];
            b_next   = chain_reg[1];
            c_next   = chain_reg[2];
            d_next   = chain_reg[3];
            e_next   = chain_reg[4];
            rnd_next = 7'd0;
        end

        if (cmd.round)
        begin
            a_next = t_val;
            b_next = a_reg;
            c_next = {b_reg[1:0], b_reg[31:2]};
            d_next = c_reg;
            e_next = d_reg;
            for (int i = 0; i < 15; i++)
            begin
                w_next[i] = w_reg[i + 1];
            end
            w_next[15] = {sched_val[30:0], sched_val[31]};
            rnd_next = rnd_reg + 7'd1;
        end

        if (cmd.fold)
        begin
            chain_next[0] = chain_reg[0] + a_reg;
            chain_next[1] = chain_reg[1] + b_reg;
            chain_next[2] = chain_reg[2] + c_reg;
            chain_next[3] = chain_reg[3] + d_reg;
            chain_next[4] = chain_reg[4] + e_reg;
        end

        if (cmd.clear)
        begin
            chain_next[0] = H0_INIT;
            chain_next[1] = H1_INIT;
            chain_next[2] = H2_INIT;
            chain_next[3] = H3_INIT;
            chain_next[4] = H4_INIT;
            pos_next      = 6'd0;
            len_next      = 61'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg[0] <= H0_INIT;
            chain_reg[1] <= H1_INIT;
            chain_reg[2] <= H2_INIT;
            chain_reg[3] <= H3_INIT;
            chain_reg[4] <= H4_INIT;
            pos_reg      <= 6'd0;
            len_reg      <= 61'd0;
            rnd_reg      <= 7'd0;
        end
        else
        begin
            for (int i = 0; i < 5; i++)
            begin
                chain_reg[i] <= chain_next[i];
            end
            pos_reg <= pos_next;
            len_reg <= len_next;
            rnd_reg <= rnd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 16; i++)
        begin
            w_reg[i] <= w_next[i];
        end
        a_reg <= a_next;
        b_reg <= b_next;
        c_reg <= c_next;
        d_reg <= d_next;
        e_reg <= e_next;
    end

    assign sts.pos_last   = (pos_reg == POS_LAST);
    assign sts.pos_ge56   = (pos_reg >= POS_LEN_MIN);
    assign sts.round_last = (rnd_reg == ROUND_LAST);

    always_comb
    begin
        case (cmd.out_sel)
            3'd0:    digest_word = chain_reg[0];
            3'd1:    digest_word = chain_reg[1];
            3'd2:    digest_word = chain_reg[2];
            3'd3:    digest_word = chain_reg[3];
            default: digest_word = chain_reg[4];
        endcase
    end

endmodule

// File: rtl/core/sha1md_ctrl.sv
// SHA-1 controller: sequences byte intake, compression, padding and digest output.
module sha1md_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     byte_present,
    input  logic                     end_of_message,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [2:0]               digest_index,
    output logic                     digest_last,
    input  sha1md_pkg::sha1md_sts_t  sts,
    output sha1md_pkg::sha1md_cmd_t  cmd
);
    import sha1md_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_PAD    = 3'd1;
    localparam logic [2:0] ST_LOAD   = 3'd2;
    localparam logic [2:0] ST_COMP   = 3'd3;
    localparam logic [2:0] ST_FOLD   = 3'd4;
    localparam logic [2:0] ST_LENBLK = 3'd5;
    localparam logic [2:0] ST_OUT    = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [2:0] idx_reg, idx_next;
    logic       end_pend_reg, end_pend_next;
    logic       long_reg, long_next;
    logic       final_reg, final_next;

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        end_pend_next = end_pend_reg;
        long_next     = long_reg;
        final_next    = final_reg;
        cmd           = '0;
        cmd.out_sel   = idx_reg;
        in_ready      = 1'b0;
        out_valid     = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.byte_wr = byte_present;
                    if (byte_present && sts.pos_last)
                    begin
                        state_next    = ST_LOAD;
                        end_pend_next = end_of_message;
                    end
                    else if (end_of_message)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                cmd.pad       = 1'b1;
                end_pend_next = 1'b0;
                long_next     = sts.pos_ge56;
                final_next    = !sts.pos_ge56;
                state_next    = ST_LOAD;
            end
            ST_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = ST_COMP;
            end
            ST_COMP:
            begin
                cmd.round = 1'b1;
                if (sts.round_last)
                begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                cmd.fold = 1'b1;
                if (final_reg)
                begin
                    idx_next   = 3'd0;
                    state_next = ST_OUT;
                end
                else if (long_reg)
                begin
                    long_next  = 1'b0;
                    state_next = ST_LENBLK;
                end
                else if (end_pend_reg)
                begin
                    state_next = ST_PAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_LENBLK:
            begin
                cmd.len_blk = 1'b1;
                final_next  = 1'b1;
                state_next  = ST_LOAD;
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (idx_reg == DIGEST_LAST)
                    begin
                        cmd.clear  = 1'b1;
                        final_next = 1'b0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            idx_reg      <= 3'd0;
            end_pend_reg <= 1'b0;
            long_reg     <= 1'b0;
            final_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            end_pend_reg <= end_pend_next;
            long_reg     <= long_next;
            final_reg    <= final_next;
        end
    end

    assign digest_index = idx_reg;
    assign digest_last  = (idx_reg == DIGEST_LAST);

endmodule

// File: rtl/core/sha1_message_digest_core.sv
// Top level of the byte-serial SHA-1 message digest core.
//
//  channel  | handshake           | payload
//  ---------+---------------------+------------------------------------------
//  input    | in_valid / in_ready | message_byte, byte_present, end_of_message
//  output   | out_valid/out_ready | digest_word, digest_index, digest_last
//
// A byte beat that does not fill a block only stores the byte. The beat
// that completes a 64-byte block starts a compression: load the working
// words, 80 rounds on the single round unit, fold into the chaining words.
// A closing beat adds a padding step and one compression, or two with an
// extra length block when the block offset is 56 or more; then five
// digest beats follow. Reset returns the initial hash values and zero length.
// Input is held off (in_ready low) while padding, compressing or emitting the digest;
// output stalls simply hold the current digest word.
`include "assert_macros.svh"

module sha1_message_digest_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  message_byte,
    input  logic        byte_present,
    input  logic        end_of_message,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  digest_index,
    output logic        digest_last
);
    import sha1md_pkg::*;

    sha1md_cmd_t cmd;
    sha1md_sts_t sts;

    // Sequencer: decides which datapath operation runs each cycle.
    sha1md_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .byte_present   (byte_present),
        .end_of_message (end_of_message),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .digest_index   (digest_index),
        .digest_last    (digest_last),
        .sts            (sts),
        .cmd            (cmd)
    );

    // Block store, schedule, round unit and chaining words.
    sha1md_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .message_byte (message_byte),
        .sts          (sts),
        .digest_word  (digest_word)
    );

    // Never accept input while a digest word is on offer.
    `ASSERT_NOW(a_no_overlap, clk, rst_n, out_valid, !in_ready)
    // The index stays inside the five digest words.
    `ASSERT_NOW(a_index_range, clk, rst_n, out_valid, digest_index <= DIGEST_LAST)
    // A taken non-final digest beat advances to the next word.
    `ASSERT_NEXT(a_index_step, clk, rst_n, out_valid && out_ready && !digest_last, out_valid && (digest_index == $past(digest_index) + 3'd1))
    // After the final digest beat, return to taking input.
    `ASSERT_NEXT(a_back_idle, clk, rst_n, out_valid && out_ready && digest_last, in_ready && !out_valid)

endmodule

// File: tb/sha1_message_digest_core_tb.sv
// Self-checking testbench for the byte-serial SHA-1 message digest core.
`timescale 1ns / 1ps

module sha1_message_digest_core_tb;

    import sha1md_pkg::*;

    localparam int CLK_PERIOD  = 8;
    localparam int RESET_CYCLES = 5;
    // Longest legal run with no beat on either channel: a closing beat with an
    // extra length block plus a receiver stall, well below this limit.
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 200;
    localparam int RANDOM_BEATS = 160;
    localparam int QUIET_AFTER  = 130;
    localparam int MAX_REPORTS  = 10;
    localparam int DIR_ROWS     = 17;

    localparam logic [159:0] EMPTY_DIGEST =
        160'hda39a3ee_5e6b4b0d_3255bfef_95601890_afd80709;

    // One digest beat as seen on the output channel.
    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_beat_t;

    // One row of the directed stimulus; digest is used only when known is set.
    typedef struct packed {
        logic [7:0]   mbyte;
        logic         present;
        logic         close;
        logic         known;
        logic [159:0] digest;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  message_byte;
    logic        byte_present;
    logic        end_of_message;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] digest_word;
    logic [2:0]  digest_index;
    logic        digest_last;

    sha1_message_digest_core u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .message_byte   (message_byte),
        .byte_present   (byte_present),
        .end_of_message (end_of_message),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .digest_word    (digest_word),
        .digest_index   (digest_index),
        .digest_last    (digest_last)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // Digest predictor: its own copy of the chaining words, the block
    // buffer, the byte offset and the running byte count.
    // ------------------------------------------------------------------
    logic [31:0] hash_state [5];
    logic [31:0] msg_block  [16];
    logic [5:0]  block_ofs;
    logic [60:0] byte_count;
    logic [31:0] final_digest [5];

    digest_beat_t digest_queue [$];

    int  error_count;
    int  words_checked;
    int  beats_sent;
    int  ignored_beats;
    int  messages_closed;
    bit  quiet_phase;

    function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic void restart_digest();
        hash_state[0] = H0_INIT;
        hash_state[1] = H1_INIT;
        hash_state[2] = H2_INIT;
        hash_state[3] = H3_INIT;
        hash_state[4] = H4_INIT;
        block_ofs     = '0;
        byte_count    = '0;
    endfunction

    // Run the 80 rounds over msg_block and fold into hash_state.
    function automatic void compress_block();
        logic [31:0] w [80];
        logic [31:0] a, b, c, d, e, f, kc, t;
        int r;
        for (r = 0; r < 16; r++)
            w[r] = msg_block[r];
        for (r = 16; r < 80; r++)
            w[r] = rotl32(w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16], 1);
        a = hash_state[0];
        b = hash_state[1];
        c = hash_state[2];
        d = hash_state[3];
        e = hash_state[4];
        for (r = 0; r < 80; r++)
        begin
            if (r < 20)
            begin
                f  = (b & c) | (~b & d);
                kc = K_R0;
            end
            else if (r < 40)
            begin
                f  = b ^ c ^ d;
                kc = K_R1;
            end
            else if (r < 60)
            begin
                f  = (b & c) | (b & d) | (c & d);
                kc = K_R2;
            end
            else
            begin
                f  = b ^ c ^ d;
                kc = K_R3;
            end
            t = rotl32(a, 5) + f + e + kc + w[r];
            e = d;
            d = c;
            c = rotl32(b, 30);
            b = a;
            a = t;
        end
        hash_state[0] += a;
        hash_state[1] += b;
        hash_state[2] += c;
        hash_state[3] += d;
        hash_state[4] += e;
    endfunction

    // Pack one byte big-endian; the first byte of a word overwrites it whole.
    function automatic void place_byte(input logic [7:0] v);
        logic [3:0]  widx;
        int unsigned sh;
        widx = block_ofs[5:2];
        sh   = (3 - block_ofs[1:0]) * 8;
        if (block_ofs[1:0] == 2'd0)
            msg_block[widx] = {24'h000000, v} << sh;
        else
            msg_block[widx] = msg_block[widx] | ({24'h000000, v} << sh);
        block_ofs = block_ofs + 6'd1;
    endfunction

    // Advance the predictor by one accepted beat; return 1 on a closing beat,
    // with the digest left in final_digest.
    function automatic bit absorb_beat(input logic [7:0] v, input logic p, input logic e);
        logic [5:0]  ofs;
        logic [63:0] bit_len;
        int k;
        if (p)
        begin
            place_byte(v);
            byte_count = byte_count + 61'd1;
            if (block_ofs == 6'd0)
                compress_block();
        end
        if (!e)
            return 1'b0;
        ofs = block_ofs;
        place_byte(PAD_BYTE);
        for (k = int'(ofs[5:2]) + 1; k < 16; k++)
            msg_block[k] = '0;
        // No room for the length: finish this block, then a length-only one.
        if (ofs >= POS_LEN_MIN)
        begin
            compress_block();
            for (k = 0; k < 14; k++)
                msg_block[k] = '0;
        end
        bit_len       = {byte_count, 3'b000};
        msg_block[14] = bit_len[63:32];
        msg_block[15] = bit_len[31:0];
        compress_block();
        for (k = 0; k < 5; k++)
            final_digest[k] = hash_state[k];
        restart_digest();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Drop valid and scramble the idle payload while the sender holds off.
    task automatic hold_off(input int n);
        in_valid       <= 1'b0;
        message_byte   <= 8'($urandom_range(0, 255));
        byte_present   <= 1'($urandom_range(0, 1));
        end_of_message <= 1'($urandom_range(0, 1));
        repeat (n) @(posedge clk);
    endtask

    task automatic maybe_gap();
        if (!quiet_phase && $urandom_range(0, 3) == 0)
            hold_off($urandom_range(1, 5));
    endtask

    // Hold the beat until accepted, then queue its digest if it closes.
    task automatic send_beat(input logic [7:0] v, input logic p, input logic e,
                             input logic known, input logic [159:0] known_digest);
        digest_beat_t item;
        int k;
        in_valid       <= 1'b1;
        message_byte   <= v;
        byte_present   <= p;
        end_of_message <= e;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (p || e)
            beats_sent++;
        else
            ignored_beats++;
        if (absorb_beat(v, p, e))
        begin
            messages_closed++;
            for (k = 0; k < 5; k++)
            begin
                item.word  = known ? known_digest[159 - 32*k -: 32] : final_digest[k];
                item.index = 3'(k);
                item.last  = (3'(k) == DIGEST_LAST);
                digest_queue = {digest_queue, item};
            end
        end
    endtask

    // Hold the sender until every queued digest beat has drained.
    task automatic wait_drained();
        while (digest_queue.size() != 0)
            hold_off(1);
    endtask

    // ------------------------------------------------------------------
    // Output side: random backpressure and the digest checker.
    // ------------------------------------------------------------------
    int stall_left;

    always @(posedge clk)
    begin
        digest_beat_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (digest_queue.size() == 0)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("[%0t] unexpected digest beat: word=%h index=%0d last=%0b",
                                 $realtime, digest_word, digest_index, digest_last);
                end
                else
                begin
                    want = digest_queue.pop_front();
                    words_checked++;
                    if (digest_word !== want.word || digest_index !== want.index ||
                        digest_last !== want.last)
                    begin
                        error_count++;
                        if (error_count <= MAX_REPORTS)
                            $display("[%0t] mismatch: exp %h/%0d/%0b got %h/%0d/%0b",
                                     $realtime, want.word, want.index, want.last,
                                     digest_word, digest_index, digest_last);
                    end
                end
            end
            // Stall in random bursts; stop stalling in the quiet tail.
            if (stall_left != 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (!quiet_phase && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 5) - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Watchdog: end the run if neither channel moves a beat for too long.
    int quiet_cycles;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("[%0t] watchdog: no beat for %0d cycles", $realtime, quiet_cycles);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    stim_row_t dir_rows [DIR_ROWS];

    initial
    begin
        int row;
        int msg_len;
        int pick;
        int i;
        int dir_beats;
        bit end_on_byte;

        clk            = 1'b0;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        message_byte   = '0;
        byte_present   = 1'b0;
        end_of_message = 1'b0;
        out_ready      = 1'b0;
        stall_left     = 0;
        quiet_cycles   = 0;
        error_count    = 0;
        words_checked  = 0;
        beats_sent     = 0;
        ignored_beats  = 0;
        messages_closed = 0;
        quiet_phase    = 1'b0;
        for (i = 0; i < 16; i++)
            msg_block[i] = '0;
        restart_digest();

        // Directed rows: ignored beats, the empty message (after reset and
        // right after a close), single extreme bytes, a byte carrying the end
        // mark, an end-only close, and an ignored beat inside a message.
        dir_rows = '{
            '{8'h00, 1'b0, 1'b0, 1'b0, 160'h0},
            '{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},
            '{8'hff, 1'b1, 1'b1, 1'b0, 160'h0},
            '{8'h00, 1'b1, 1'b1, 1'b0, 160'h0},
            '{8'hff, 1'b0, 1'b0, 1'b0, 160'h0},
            '{8'h61, 1'b1, 1'b0, 1'b0, 160'h0},
            '{8'h62, 1'b1, 1'b0, 1'b0, 160'h0},
            '{8'h63, 1'b1, 1'b1, 1'b0, 160'h0},
            '{8'h5a, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},
            '{8'h61, 1'b1, 1'b0, 1'b0, 160'h0},
            '{8'ha5, 1'b0, 1'b0, 1'b0, 160'h0},
            '{8'h62, 1'b1, 1'b0, 1'b0, 160'h0},
            '{8'h00, 1'b0, 1'b1, 1'b0, 160'h0},
            '{8'h55, 1'b1, 1'b0, 1'b0, 160'h0},
            '{8'haa, 1'b1, 1'b0, 1'b0, 160'h0},
            '{8'h01, 1'b1, 1'b0, 1'b0, 160'h0},
            '{8'h80, 1'b1, 1'b1, 1'b0, 160'h0}
        };

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (row = 0; row < DIR_ROWS; row++)
        begin
            maybe_gap();
            send_beat(dir_rows[row].mbyte, dir_rows[row].present, dir_rows[row].close,
                      dir_rows[row].known, dir_rows[row].digest);
        end
        wait_drained();
        dir_beats  = beats_sent;
        beats_sent = 0;

        // Random messages: mostly short, often right at the padding boundary
        // (offsets 54..57 and 62..65), some spanning a block, with ignored
        // beats sprinkled in as noise.
        while (beats_sent < RANDOM_BEATS)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 5)
                msg_len = $urandom_range(0, 12);
            else if (pick < 8)
                msg_len = 54 + $urandom_range(0, 3) + 8 * $urandom_range(0, 1);
            else
                msg_len = $urandom_range(13, 70);
            end_on_byte = (msg_len != 0) && ($urandom_range(0, 1) == 1);
            for (i = 0; i < msg_len; i++)
            begin
                if (beats_sent >= QUIET_AFTER)
                    quiet_phase = 1'b1;
                if ($urandom_range(0, 9) == 0)
                begin
                    maybe_gap();
                    send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, 160'h0);
                end
                maybe_gap();
                send_beat(8'($urandom_range(0, 255)), 1'b1,
                          end_on_byte && (i == msg_len - 1), 1'b0, 160'h0);
            end
            if (!end_on_byte)
            begin
                maybe_gap();
                send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, 160'h0);
            end
            if (!quiet_phase && $urandom_range(0, 3) == 0)
                wait_drained();
        end

        // Drain: wait out every digest beat, then watch for strays.
        quiet_phase = 1'b1;
        hold_off(1);
        while (digest_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d messages from %0d data/end beats and %0d ignored beats,",
                 messages_closed, beats_sent + dir_beats, ignored_beats);
        $display("with closes at and across the length boundary; %0d digest words checked.",
                 words_checked);
        if (error_count == 0 && digest_queue.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
